FILE: hdl/pls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types, codes and defaults for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int PLS_CAPACITY   = 16;
	localparam int PLS_DATA_WIDTH = 32;

	// fixed word field widths
	localparam int OPCODE_W = 3;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [OPCODE_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_DELETE   = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_RETRIEVE = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_LOCATE   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOPOS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_WAIT,
		S_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic commit;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rem_zero;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: hdl/pls_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pls_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface pls_cmd_if import pls_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic        [OPCODE_W-1:0] opcode;
	logic        [POS_W-1:0]    position;
	logic signed [VALUE_W-1:0]  item_value;

	modport source (output valid, output opcode, output position, output item_value,
		input ready);
	modport sink (input valid, input opcode, input position, input item_value,
		output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic        [STATUS_W-1:0] status;
	logic signed [VALUE_W-1:0]  read_value;
	logic        [POS_W-1:0]    found_position;
	logic        [POS_W-1:0]    length_now;

	modport source (output valid, output status, output read_value,
		output found_position, output length_now, input ready);
	modport sink (input valid, input status, input read_value,
		input found_position, input length_now, output ready);
endinterface
`default_nettype wire

FILE: hdl/pls_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ctrl
// Sequencer: accept a word, step the entry scan, commit into the output slot.
// ----------------------------------------------------------------------------
module pls_ctrl import pls_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output ctrl_cmd_t      cmd,
	input  wire dp_sts_t   sts
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				if (sts.rem_zero) begin
					state_d = S_WAIT;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			// spare state after the last write-back, before commit
			S_WAIT: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: hdl/pls_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pls_dpath
// Entry memory, length count, shift/scan pipe and response register.
// ----------------------------------------------------------------------------
module pls_dpath import pls_pkg::*; #(
	parameter int CAPACITY   = PLS_CAPACITY,
	parameter int DATA_WIDTH = PLS_DATA_WIDTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ctrl_cmd_t                  cmd,
	output dp_sts_t                         sts,
	input  wire logic        [OPCODE_W-1:0] opcode,
	input  wire logic        [POS_W-1:0]    position,
	input  wire logic signed [VALUE_W-1:0]  item_value,
	output logic             [STATUS_W-1:0] status,
	output logic signed      [VALUE_W-1:0]  read_value,
	output logic             [POS_W-1:0]    found_position,
	output logic             [POS_W-1:0]    length_now
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int FW   = $clog2(CAPACITY + 2);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [DATA_WIDTH-1:0] mem [CAPACITY];

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         rem_q;
	logic [AW-1:0]         idx_q;
	logic [OPCODE_W-1:0]   op_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic                  ok_q;
	logic [STATUS_W-1:0]   status_q;
	logic [FW-1:0]         found_q;
	logic                  hit_q;

	logic                  pend_s1;
	logic [AW-1:0]         addr_s1;
	logic [DATA_WIDTH-1:0] rd_data_s1;

	logic [STATUS_W-1:0]   rsp_status_q;
	logic [VALUE_W-1:0]    rsp_read_q;
	logic [POS_W-1:0]      rsp_found_q;
	logic [POS_W-1:0]      rsp_len_q;

	// load decode
	logic [CMPW-1:0]       pos_w;
	logic [CMPW-1:0]       cnt_w;
	logic [CMPW-1:0]       ld_rem;
	logic [CMPW-1:0]       ld_idx;
	logic [STATUS_W-1:0]   ld_status;
	logic                  ld_ok;

	// write port
	logic                  we;
	logic [AW-1:0]         wa;
	logic [DATA_WIDTH-1:0] wd;

	logic [CW-1:0]         count_d;

	always_comb begin
		pos_w     = CMPW'(position);
		cnt_w     = CMPW'(count_q);
		ld_rem    = '0;
		ld_idx    = '0;
		ld_status = STAT_OK;
		ld_ok     = 1'b0;
		case (opcode)
			OP_INSERT: begin
				if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
					ld_status = STAT_NOPOS;
				end else if (cnt_w >= CMPW'(CAPACITY)) begin
					ld_status = STAT_FULL;
				end else begin
					ld_ok  = 1'b1;
					ld_rem = cnt_w - pos_w + CMPW'(1);
					ld_idx = cnt_w - CMPW'(1);
				end
			end
			OP_DELETE: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					ld_status = STAT_NOPOS;
				end else begin
					ld_ok  = 1'b1;
					ld_rem = cnt_w - pos_w;
					ld_idx = pos_w;
				end
			end
			OP_RETRIEVE: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					ld_status = STAT_NOPOS;
				end else begin
					ld_ok  = 1'b1;
					ld_rem = CMPW'(1);
					ld_idx = pos_w - CMPW'(1);
				end
			end
			OP_LOCATE: begin
				ld_rem = cnt_w;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			pend_s1 <= 1'b0;
			count_q <= '0;
		end else begin
			pend_s1 <= cmd.rd_en;
			if (cmd.load) begin
				rem_q <= ld_rem[CW-1:0];
			end else if (cmd.rd_en) begin
				rem_q <= rem_q - CW'(1);
			end
			if (cmd.commit) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= opcode;
			pos_q    <= position;
			val_q    <= DATA_WIDTH'($unsigned(item_value));
			ok_q     <= ld_ok;
			status_q <= ld_status;
			idx_q    <= ld_idx[AW-1:0];
			found_q  <= FW'(count_q) + FW'(1);
			hit_q    <= 1'b0;
		end else if (cmd.rd_en) begin
			// insert shifts from the tail down, the others walk up
			if (op_q == OP_INSERT) begin
				idx_q <= idx_q - AW'(1);
			end else begin
				idx_q <= idx_q + AW'(1);
			end
		end
		if (pend_s1 && op_q == OP_LOCATE && !hit_q && rd_data_s1 == val_q) begin
			hit_q   <= 1'b1;
			found_q <= FW'(addr_s1) + FW'(1);
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[idx_q];
			addr_s1    <= idx_q;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = addr_s1;
		wd = rd_data_s1;
		if (pend_s1 && op_q == OP_INSERT) begin
			we = 1'b1;
			wa = addr_s1 + AW'(1);
		end else if (pend_s1 && op_q == OP_DELETE) begin
			we = 1'b1;
			wa = addr_s1 - AW'(1);
		end else if (cmd.commit && op_q == OP_INSERT && ok_q) begin
			we = 1'b1;
			wa = AW'(CMPW'(pos_q) - CMPW'(1));
			wd = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_comb begin
		count_d = count_q;
		if (op_q == OP_INSERT && ok_q) begin
			count_d = count_q + CW'(1);
		end else if (op_q == OP_DELETE && ok_q) begin
			count_d = count_q - CW'(1);
		end else if (op_q == OP_CLEAR) begin
			count_d = '0;
		end
	end

	// response register, loaded on commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_status_q <= status_q;
			rsp_read_q   <= (op_q == OP_RETRIEVE && ok_q) ? VALUE_W'(rd_data_s1) : '0;
			rsp_found_q  <= (op_q == OP_LOCATE) ? POS_W'(found_q) : '0;
			rsp_len_q    <= POS_W'(count_d);
		end
	end

	assign sts.rem_zero   = (rem_q == '0);
	assign status         = rsp_status_q;
	assign read_value     = $signed(rsp_read_q);
	assign found_position = rsp_found_q;
	assign length_now     = rsp_len_q;

endmodule
`default_nettype wire

FILE: hdl/positional_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed values with insert, delete, retrieve, locate, clear.
// ----------------------------------------------------------------------------
// Requests are taken one at a time: accept, read r entries, commit once the
//   response slot is free, where r is the entries read: length-position+1
//   for insert, length-position for delete, 1 for retrieve, length for
//   locate, 0 for clear, spare opcodes and failures. One entry is read per
//   cycle, written back in the next; the response register frees the input side.
// Reset: list empty, no response pending; entry memory is not cleared.
module positional_list_store import pls_pkg::*; #(
	parameter int CAPACITY   = PLS_CAPACITY,
	parameter int DATA_WIDTH = PLS_DATA_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pls_cmd_if.sink   cmd,
	pls_rsp_if.source rsp
);

	ctrl_cmd_t ctl;
	dp_sts_t   dp_sts;
	logic      in_ready;
	logic      out_valid;

	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.cmd       (ctl),
		.sts       (dp_sts)
	);

	pls_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl),
		.sts            (dp_sts),
		.opcode         (cmd.opcode),
		.position       (cmd.position),
		.item_value     (cmd.item_value),
		.status         (rsp.status),
		.read_value     (rsp.read_value),
		.found_position (rsp.found_position),
		.length_now     (rsp.length_now)
	);

	assign cmd.ready = in_ready;
	assign rsp.valid = out_valid;

	// one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("request accepted while another is in flight");

	// full is only reported with the list at capacity
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_FULL |-> rsp.length_now == POS_W'(CAPACITY))
		else $error("full status with list below capacity");

	// read data and locate result never come from the same operation
	a_read_xor_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.read_value != '0 |-> rsp.found_position == '0)
		else $error("read value and locate result both set");

	// failed operations return no data
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_OK |-> rsp.read_value == '0)
		else $error("failed operation returned data");

endmodule
`default_nettype wire
